FILE: rtl/dcc_lpb_pkg.sv
package dcc_lpb_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    MODE_SPEED = 2'd0,
    MODE_FUNC  = 2'd1,
    MODE_POLL  = 2'd2
  } mode_e;

  // Packet length codes
  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_SHORT = 2'd2;
  localparam logic [1:0] LEN_LONG  = 2'd3;

  // Instruction byte constants
  localparam logic [7:0] INSTR_SPEED128 = 8'h3F;
  localparam logic [7:0] INSTR_GRP_A    = 8'h80;
  localparam logic [7:0] INSTR_GRP_B    = 8'hB0;
  localparam logic [7:0] INSTR_GRP_C    = 8'hA0;
  localparam logic [7:0] INSTR_GRP_D    = 8'hDE;
  localparam logic [7:0] INSTR_GRP_E    = 8'hDF;

  // Function number boundaries of the groups
  localparam logic [4:0] FN_LAST_A  = 5'd4;
  localparam logic [4:0] FN_LAST_B  = 5'd8;
  localparam logic [4:0] FN_LAST_C  = 5'd12;
  localparam logic [4:0] FN_LAST_D  = 5'd20;
  localparam logic [4:0] FN_LAST_E  = 5'd28;
  localparam logic [4:0] FN_FIRST_B = 5'd5;
  localparam logic [4:0] FN_FIRST_C = 5'd9;
  localparam logic [4:0] FN_FIRST_D = 5'd13;
  localparam logic [4:0] FN_FIRST_E = 5'd21;

  localparam logic [4:0] SPEED_MAX = 5'd31;

  typedef struct packed {
    logic [1:0]  mode;
    logic [13:0] loco_address;
    logic [4:0]  speed_step;
    logic        forwards;
    logic [4:0]  function_number;
    logic        function_on;
    logic        generator_busy;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] length;
  } packet_t;

endpackage

FILE: rtl/dcc_lpb_if.sv
// Input channel: one command item per transfer
interface dcc_lpb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [13:0] loco_address;
  logic [4:0]  speed_step;
  logic        forwards;
  logic [4:0]  function_number;
  logic        function_on;
  logic        generator_busy;

  modport source (
    output valid, mode, loco_address, speed_step, forwards,
           function_number, function_on, generator_busy,
    input  ready
  );
  modport sink (
    input  valid, mode, loco_address, speed_step, forwards,
           function_number, function_on, generator_busy,
    output ready
  );
endinterface

// Output channel: one DCC packet per transfer
interface dcc_lpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte0;
  logic [7:0] packet_byte1;
  logic [7:0] packet_byte2;
  logic [1:0] packet_length;

  modport source (
    output valid, packet_byte0, packet_byte1, packet_byte2, packet_length,
    input  ready
  );
  modport sink (
    input  valid, packet_byte0, packet_byte1, packet_byte2, packet_length,
    output ready
  );
endinterface

FILE: rtl/dcc_lpb_state.sv
// Locomotive state (sent and wanted copies) and the packet builder.
module dcc_lpb_state (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  dcc_lpb_pkg::item_t   item_i,
  output dcc_lpb_pkg::packet_t pkt_o
);

  logic [13:0] addr_q, addr_d;
  logic [4:0]  sent_spd_q, sent_spd_d, want_spd_q, want_spd_d;
  logic        sent_dir_q, sent_dir_d, want_dir_q, want_dir_d;
  logic [4:0]  sent_a_q, sent_a_d, want_a_q, want_a_d;
  logic [3:0]  sent_b_q, sent_b_d, want_b_q, want_b_d;
  logic [3:0]  sent_c_q, sent_c_d, want_c_q, want_c_d;
  logic [7:0]  sent_d_q, sent_d_d, want_d_q, want_d_d;
  logic [7:0]  sent_e_q, sent_e_d, want_e_q, want_e_d;

  logic [4:0]  spd_store;
  logic [4:0]  fn;
  logic [4:0]  off_b, off_c, off_d, off_e;
  logic        busy;

  assign fn    = item_i.function_number;
  assign busy  = item_i.generator_busy;
  assign off_b = fn - dcc_lpb_pkg::FN_FIRST_B;
  assign off_c = fn - dcc_lpb_pkg::FN_FIRST_C;
  assign off_d = fn - dcc_lpb_pkg::FN_FIRST_D;
  assign off_e = fn - dcc_lpb_pkg::FN_FIRST_E;

  // Nonzero speeds skip the emergency-stop code, saturating at the top
  always_comb begin
    if (item_i.speed_step == 5'd0) begin
      spd_store = 5'd0;
    end else if (item_i.speed_step == dcc_lpb_pkg::SPEED_MAX) begin
      spd_store = dcc_lpb_pkg::SPEED_MAX;
    end else begin
      spd_store = item_i.speed_step + 5'd1;
    end
  end

  // Next state and packet
  always_comb begin
    addr_d     = addr_q;
    sent_spd_d = sent_spd_q;
    want_spd_d = want_spd_q;
    sent_dir_d = sent_dir_q;
    want_dir_d = want_dir_q;
    sent_a_d   = sent_a_q;
    want_a_d   = want_a_q;
    sent_b_d   = sent_b_q;
    want_b_d   = want_b_q;
    sent_c_d   = sent_c_q;
    want_c_d   = want_c_q;
    sent_d_d   = sent_d_q;
    want_d_d   = want_d_q;
    sent_e_d   = sent_e_q;
    want_e_d   = want_e_q;

    pkt_o.valid  = 1'b0;
    pkt_o.byte0  = addr_q[7:0];
    pkt_o.byte1  = 8'd0;
    pkt_o.byte2  = 8'd0;
    pkt_o.length = dcc_lpb_pkg::LEN_NONE;

    unique case (dcc_lpb_pkg::mode_e'(item_i.mode))
      dcc_lpb_pkg::MODE_SPEED: begin
        addr_d     = item_i.loco_address;
        want_spd_d = spd_store;
        want_dir_d = item_i.forwards;
      end
      dcc_lpb_pkg::MODE_FUNC: begin
        addr_d = item_i.loco_address;
        priority if (fn <= dcc_lpb_pkg::FN_LAST_A) begin
          want_a_d[fn[2:0]] = item_i.function_on;
        end else if (fn <= dcc_lpb_pkg::FN_LAST_B) begin
          want_b_d[off_b[1:0]] = item_i.function_on;
        end else if (fn <= dcc_lpb_pkg::FN_LAST_C) begin
          want_c_d[off_c[1:0]] = item_i.function_on;
        end else if (fn <= dcc_lpb_pkg::FN_LAST_D) begin
          want_d_d[off_d[2:0]] = item_i.function_on;
        end else if (fn <= dcc_lpb_pkg::FN_LAST_E) begin
          want_e_d[off_e[2:0]] = item_i.function_on;
        end else begin
          // function numbers above 28 only store the address
        end
      end
      dcc_lpb_pkg::MODE_POLL: begin
        if (!busy) begin
          // first differing group in fixed priority
          priority if (want_spd_q != sent_spd_q || want_dir_q != sent_dir_q) begin
            pkt_o.valid  = 1'b1;
            pkt_o.byte1  = dcc_lpb_pkg::INSTR_SPEED128;
            pkt_o.byte2  = {want_dir_q, 2'b00, want_spd_q};
            pkt_o.length = dcc_lpb_pkg::LEN_LONG;
            sent_spd_d   = want_spd_q;
            sent_dir_d   = want_dir_q;
          end else if (want_a_q != sent_a_q) begin
            pkt_o.valid  = 1'b1;
            pkt_o.byte1  = dcc_lpb_pkg::INSTR_GRP_A | {3'b000, want_a_q[0], want_a_q[4:1]};
            pkt_o.length = dcc_lpb_pkg::LEN_SHORT;
            sent_a_d     = want_a_q;
          end else if (want_b_q != sent_b_q) begin
            pkt_o.valid  = 1'b1;
            pkt_o.byte1  = dcc_lpb_pkg::INSTR_GRP_B | {4'b0000, want_b_q};
            pkt_o.length = dcc_lpb_pkg::LEN_SHORT;
            sent_b_d     = want_b_q;
          end else if (want_c_q != sent_c_q) begin
            pkt_o.valid  = 1'b1;
            pkt_o.byte1  = dcc_lpb_pkg::INSTR_GRP_C | {4'b0000, want_c_q};
            pkt_o.length = dcc_lpb_pkg::LEN_SHORT;
            sent_c_d     = want_c_q;
          end else if (want_d_q != sent_d_q) begin
            pkt_o.valid  = 1'b1;
            pkt_o.byte1  = dcc_lpb_pkg::INSTR_GRP_D;
            pkt_o.byte2  = want_d_q;
            pkt_o.length = dcc_lpb_pkg::LEN_LONG;
            sent_d_d     = want_d_q;
          end else if (want_e_q != sent_e_q) begin
            pkt_o.valid  = 1'b1;
            pkt_o.byte1  = dcc_lpb_pkg::INSTR_GRP_E;
            pkt_o.byte2  = want_e_q;
            pkt_o.length = dcc_lpb_pkg::LEN_LONG;
            sent_e_d     = want_e_q;
          end else begin
            // nothing changed
          end
        end
      end
      default: begin
        // unused mode code: ignored
      end
    endcase
  end

  // State registers, updated once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      sent_spd_q <= '0;
      want_spd_q <= '0;
      sent_dir_q <= 1'b0;
      want_dir_q <= 1'b0;
      sent_a_q   <= '0;
      want_a_q   <= '0;
      sent_b_q   <= '0;
      want_b_q   <= '0;
      sent_c_q   <= '0;
      want_c_q   <= '0;
      sent_d_q   <= '0;
      want_d_q   <= '0;
      sent_e_q   <= '0;
      want_e_q   <= '0;
    end else if (fire_i) begin
      addr_q     <= addr_d;
      sent_spd_q <= sent_spd_d;
      want_spd_q <= want_spd_d;
      sent_dir_q <= sent_dir_d;
      want_dir_q <= want_dir_d;
      sent_a_q   <= sent_a_d;
      want_a_q   <= want_a_d;
      sent_b_q   <= sent_b_d;
      want_b_q   <= want_b_d;
      sent_c_q   <= sent_c_d;
      want_c_q   <= want_c_d;
      sent_d_q   <= sent_d_d;
      want_d_q   <= want_d_d;
      sent_e_q   <= sent_e_d;
      want_e_q   <= want_e_d;
    end
  end

endmodule

FILE: rtl/dcc_loco_packet_builder.sv
// DCC packet builder for one locomotive. Set-speed and set-function items
// update the wanted copy of the locomotive state; a poll item with the
// generator not busy returns one packet for the first group whose wanted copy
// differs from the sent copy (speed/direction, F0-4, F5-8, F9-12, F13-20,
// F21-28) and marks that group sent. Set items, busy polls and polls with
// nothing changed return no packet. Each item passes an input register and is
// then processed into a packet register, so one item is taken per cycle while
// the input stage does not stall; the packet register holds a result until it
// is taken, and the input stage stalls only while that register is full and
// not being taken and a new item waits in the input register.
module dcc_loco_packet_builder (
  input  logic          clk_i,
  input  logic          rst_ni,
  dcc_lpb_in_if.sink    in_if,
  dcc_lpb_out_if.source out_if
);

  dcc_lpb_pkg::item_t   item_q;
  logic                 item_vld_q;
  dcc_lpb_pkg::packet_t pkt;
  dcc_lpb_pkg::packet_t pkt_q;
  logic                 out_vld_q;
  logic                 advance;
  logic                 in_xfer;

  // Stage control
  assign advance     = item_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !item_vld_q || advance;
  assign in_xfer     = in_if.valid && in_if.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_xfer) begin
      item_vld_q <= 1'b1;
    end else if (advance) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.mode            <= in_if.mode;
      item_q.loco_address    <= in_if.loco_address;
      item_q.speed_step      <= in_if.speed_step;
      item_q.forwards        <= in_if.forwards;
      item_q.function_number <= in_if.function_number;
      item_q.function_on     <= in_if.function_on;
      item_q.generator_busy  <= in_if.generator_busy;
    end
  end

  dcc_lpb_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .pkt_o  (pkt)
  );

  // Packet register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && pkt.valid) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pkt.valid) begin
      pkt_q <= pkt;
    end
  end

  assign out_if.valid         = out_vld_q;
  assign out_if.packet_byte0  = pkt_q.byte0;
  assign out_if.packet_byte1  = pkt_q.byte1;
  assign out_if.packet_byte2  = pkt_q.byte2;
  assign out_if.packet_length = pkt_q.length;

`ifndef SYNTHESIS
  // A new packet only appears after an item was processed
  a_pkt_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(advance))
    else $error("packet appeared without a processed item");

  // Valid packets are two or three bytes long
  a_pkt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (pkt_q.length == dcc_lpb_pkg::LEN_SHORT ||
                   pkt_q.length == dcc_lpb_pkg::LEN_LONG))
    else $error("packet length out of range");

  // Long packets carry one of the three-byte instructions
  a_long_instr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && pkt_q.length == dcc_lpb_pkg::LEN_LONG) |->
      (pkt_q.byte1 == dcc_lpb_pkg::INSTR_SPEED128 ||
       pkt_q.byte1 == dcc_lpb_pkg::INSTR_GRP_D ||
       pkt_q.byte1 == dcc_lpb_pkg::INSTR_GRP_E))
    else $error("long packet with short instruction");

  // Short packets have an empty data byte
  a_short_b2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && pkt_q.length == dcc_lpb_pkg::LEN_SHORT) |-> pkt_q.byte2 == 8'd0)
    else $error("short packet with data byte");
`endif

endmodule

FILE: tb/dcc_lpb_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow of the locomotive state and checks
// every packet against the oldest one predicted.
module dcc_lpb_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  dcc_lpb_in_if  in_mon,
  dcc_lpb_out_if out_mon,
  output int     fail_count_o,
  output int     pending_o
);

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] length;
  } dcc_packet_t;

  dcc_packet_t packets_due[$];
  int          fails = 0;

  // Shadow of the locomotive state: sent copy and wanted copy
  logic [13:0] address_q;
  logic [4:0]  speed_sent, speed_want;
  logic        dir_sent, dir_want;
  logic [4:0]  grp_a_sent, grp_a_want;
  logic [3:0]  grp_b_sent, grp_b_want;
  logic [3:0]  grp_c_sent, grp_c_want;
  logic [7:0]  grp_d_sent, grp_d_want;
  logic [7:0]  grp_e_sent, grp_e_want;

  task automatic queue_packet(input logic [7:0] instr, input logic [7:0] data,
                              input logic [1:0] len);
    dcc_packet_t p;
    p.byte0  = address_q[7:0];
    p.byte1  = instr;
    p.byte2  = data;
    p.length = len;
    packets_due.push_back(p);
  endtask

  // Apply one command to the shadow state; a poll may queue one packet
  task automatic predict_packet(input dcc_lpb_pkg::item_t c);
    int idx;
    idx = c.function_number;
    case (c.mode)
      dcc_lpb_pkg::MODE_SPEED: begin
        address_q = c.loco_address;
        // skip the emergency-stop code, saturate at the top step
        if (c.speed_step == 5'd0) speed_want = 5'd0;
        else if (c.speed_step == dcc_lpb_pkg::SPEED_MAX) speed_want = dcc_lpb_pkg::SPEED_MAX;
        else speed_want = c.speed_step + 5'd1;
        dir_want = c.forwards;
      end
      dcc_lpb_pkg::MODE_FUNC: begin
        address_q = c.loco_address;
        if (c.function_number <= dcc_lpb_pkg::FN_LAST_A)
          grp_a_want[idx] = c.function_on;
        else if (c.function_number <= dcc_lpb_pkg::FN_LAST_B)
          grp_b_want[idx - 5] = c.function_on;
        else if (c.function_number <= dcc_lpb_pkg::FN_LAST_C)
          grp_c_want[idx - 9] = c.function_on;
        else if (c.function_number <= dcc_lpb_pkg::FN_LAST_D)
          grp_d_want[idx - 13] = c.function_on;
        else if (c.function_number <= dcc_lpb_pkg::FN_LAST_E)
          grp_e_want[idx - 21] = c.function_on;
      end
      dcc_lpb_pkg::MODE_POLL: begin
        if (!c.generator_busy) begin
          // fixed priority: speed/dir, F0-4, F5-8, F9-12, F13-20, F21-28
          if (speed_want != speed_sent || dir_want != dir_sent) begin
            queue_packet(dcc_lpb_pkg::INSTR_SPEED128, {dir_want, 2'b00, speed_want},
                         dcc_lpb_pkg::LEN_LONG);
            speed_sent = speed_want;
            dir_sent   = dir_want;
          end else if (grp_a_want != grp_a_sent) begin
            // FL goes to bit 4, F1..F4 to bits 0..3
            queue_packet(dcc_lpb_pkg::INSTR_GRP_A |
                         {3'b000, grp_a_want[0], grp_a_want[4:1]},
                         8'h00, dcc_lpb_pkg::LEN_SHORT);
            grp_a_sent = grp_a_want;
          end else if (grp_b_want != grp_b_sent) begin
            queue_packet(dcc_lpb_pkg::INSTR_GRP_B | {4'h0, grp_b_want}, 8'h00,
                         dcc_lpb_pkg::LEN_SHORT);
            grp_b_sent = grp_b_want;
          end else if (grp_c_want != grp_c_sent) begin
            queue_packet(dcc_lpb_pkg::INSTR_GRP_C | {4'h0, grp_c_want}, 8'h00,
                         dcc_lpb_pkg::LEN_SHORT);
            grp_c_sent = grp_c_want;
          end else if (grp_d_want != grp_d_sent) begin
            queue_packet(dcc_lpb_pkg::INSTR_GRP_D, grp_d_want, dcc_lpb_pkg::LEN_LONG);
            grp_d_sent = grp_d_want;
          end else if (grp_e_want != grp_e_sent) begin
            queue_packet(dcc_lpb_pkg::INSTR_GRP_E, grp_e_want, dcc_lpb_pkg::LEN_LONG);
            grp_e_sent = grp_e_want;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_packet(input dcc_packet_t got);
    dcc_packet_t exp;
    if (packets_due.size() == 0) begin
      $error("packet with none due: byte0 %0h byte1 %0h byte2 %0h length %0d",
             got.byte0, got.byte1, got.byte2, got.length);
      fails++;
    end else begin
      exp = packets_due.pop_front();
      if (got.byte0 !== exp.byte0) begin
        $error("packet_byte0: expected %0h, got %0h", exp.byte0, got.byte0);
        fails++;
      end
      if (got.byte1 !== exp.byte1) begin
        $error("packet_byte1: expected %0h, got %0h", exp.byte1, got.byte1);
        fails++;
      end
      if (got.byte2 !== exp.byte2) begin
        $error("packet_byte2: expected %0h, got %0h", exp.byte2, got.byte2);
        fails++;
      end
      if (got.length !== exp.length) begin
        $error("packet_length: expected %0d, got %0d", exp.length, got.length);
        fails++;
      end
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    dcc_lpb_pkg::item_t cmd;
    dcc_packet_t        got;
    if (!rst_ni) begin
      packets_due.delete();
      address_q  = '0;
      speed_sent = '0;
      speed_want = '0;
      dir_sent   = 1'b0;
      dir_want   = 1'b0;
      grp_a_sent = '0;
      grp_a_want = '0;
      grp_b_sent = '0;
      grp_b_want = '0;
      grp_c_sent = '0;
      grp_c_want = '0;
      grp_d_sent = '0;
      grp_d_want = '0;
      grp_e_sent = '0;
      grp_e_want = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.byte0  = out_mon.packet_byte0;
        got.byte1  = out_mon.packet_byte1;
        got.byte2  = out_mon.packet_byte2;
        got.length = out_mon.packet_length;
        check_packet(got);
      end
      if (in_mon.valid && in_mon.ready) begin
        cmd.mode            = in_mon.mode;
        cmd.loco_address    = in_mon.loco_address;
        cmd.speed_step      = in_mon.speed_step;
        cmd.forwards        = in_mon.forwards;
        cmd.function_number = in_mon.function_number;
        cmd.function_on     = in_mon.function_on;
        cmd.generator_busy  = in_mon.generator_busy;
        predict_packet(cmd);
      end
    end
    fail_count_o = fails;
    pending_o    = packets_due.size();
  end

endmodule

FILE: tb/dcc_loco_packet_builder_tb.sv
`timescale 1ns / 1ps

module dcc_loco_packet_builder_tb;

  // Mode code that the block ignores
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 1900;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 12;

  logic clk;
  logic rst_n;
  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  int   effective_items    = 0;
  int   cycle_count        = 0;
  int   fail_count;
  int   pending;

  dcc_lpb_in_if  cmd_if ();
  dcc_lpb_out_if pkt_if ();

  dcc_loco_packet_builder i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (cmd_if),
    .out_if (pkt_if)
  );

  dcc_lpb_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (cmd_if),
    .out_mon      (pkt_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dcc_loco_packet_builder_tb: errors");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    pkt_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic dcc_lpb_pkg::item_t cmd(input logic [1:0] m, input logic [13:0] a,
                                             input logic [4:0] s, input logic f,
                                             input logic [4:0] n, input logic o,
                                             input logic b);
    dcc_lpb_pkg::item_t c;
    c.mode            = m;
    c.loco_address    = a;
    c.speed_step      = s;
    c.forwards        = f;
    c.function_number = n;
    c.function_on     = o;
    c.generator_busy  = b;
    return c;
  endfunction

  function automatic dcc_lpb_pkg::item_t rand_cmd();
    return cmd(2'($urandom_range(3)), 14'($urandom), 5'($urandom), 1'($urandom),
               5'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // Drive one command from a falling edge and hold it until the transfer
  task automatic send_command(input dcc_lpb_pkg::item_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid           <= 1'b1;
    cmd_if.mode            <= c.mode;
    cmd_if.loco_address    <= c.loco_address;
    cmd_if.speed_step      <= c.speed_step;
    cmd_if.forwards        <= c.forwards;
    cmd_if.function_number <= c.function_number;
    cmd_if.function_on     <= c.function_on;
    cmd_if.generator_busy  <= c.generator_busy;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    effective_items++;
    @(negedge clk);
  endtask

  initial begin
    dcc_lpb_pkg::item_t c;
    int                 base;
    int                 burst;
    rst_n                  = 1'b0;
    cmd_if.valid           = 1'b0;
    cmd_if.mode            = dcc_lpb_pkg::MODE_SPEED;
    cmd_if.loco_address    = '0;
    cmd_if.speed_step      = '0;
    cmd_if.forwards        = 1'b0;
    cmd_if.function_number = '0;
    cmd_if.function_on     = 1'b0;
    cmd_if.generator_busy  = 1'b0;
    pkt_if.ready           = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: poll on reset state, speed extremes, saturation, busy poll
    send_command(cmd(dcc_lpb_pkg::MODE_POLL, 14'd0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_SPEED, 14'h3FFF, 5'd30, 1'b1, 5'd0, 1'b0, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_POLL, 14'd0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_SPEED, 14'd0, dcc_lpb_pkg::SPEED_MAX, 1'b0,
                     5'd31, 1'b1, 1'b1));
    send_command(cmd(dcc_lpb_pkg::MODE_POLL, 14'h3FFF, 5'd31, 1'b1, 5'd31, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_SPEED, 14'h1234, 5'd1, 1'b1, 5'd0, 1'b0, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_POLL, 14'd0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b1));
    send_command(cmd(dcc_lpb_pkg::MODE_POLL, 14'd0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_SPEED, 14'h00A5, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0));
    // Every group boundary, then an out-of-range number and the unused mode
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h0001, 5'd0, 1'b0, 5'd0, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h0002, 5'd0, 1'b0,
                     dcc_lpb_pkg::FN_LAST_A, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h0003, 5'd0, 1'b0,
                     dcc_lpb_pkg::FN_FIRST_B, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h0004, 5'd0, 1'b0,
                     dcc_lpb_pkg::FN_LAST_B, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h0005, 5'd0, 1'b0,
                     dcc_lpb_pkg::FN_FIRST_C, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h0006, 5'd0, 1'b0,
                     dcc_lpb_pkg::FN_LAST_C, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h0007, 5'd0, 1'b0,
                     dcc_lpb_pkg::FN_FIRST_D, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h0008, 5'd0, 1'b0,
                     dcc_lpb_pkg::FN_LAST_D, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h0009, 5'd0, 1'b0,
                     dcc_lpb_pkg::FN_FIRST_E, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h000A, 5'd0, 1'b0,
                     dcc_lpb_pkg::FN_LAST_E, 1'b1, 1'b0));
    send_command(cmd(dcc_lpb_pkg::MODE_FUNC, 14'h2C5A, 5'd0, 1'b0, 5'd31, 1'b1, 1'b0));
    send_command(cmd(MODE_UNUSED, 14'h3FFF, 5'd31, 1'b1, 5'd31, 1'b1, 1'b0));
    // One packet for each of the six groups, speed/direction included
    repeat (6) begin
      send_command(cmd(dcc_lpb_pkg::MODE_POLL, 14'd0, 5'd0, 1'b0, 5'd0, 1'b0, 1'b0));
    end

    // Random: bursts of set commands followed by polls, with some noise
    base = effective_items;
    while (effective_items - base < RANDOM_ITEMS) begin
      case ((effective_items - base) * 4 / RANDOM_ITEMS)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
        default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
      endcase
      if ($urandom_range(9) == 0) begin
        send_command(rand_cmd());
      end else begin
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          c = rand_cmd();
          if ($urandom_range(2) == 0) begin
            c.mode       = dcc_lpb_pkg::MODE_SPEED;
            c.speed_step = ($urandom_range(15) == 0) ? dcc_lpb_pkg::SPEED_MAX
                                                     : 5'($urandom_range(30));
          end else begin
            c.mode            = dcc_lpb_pkg::MODE_FUNC;
            c.function_number = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 29))
                                                          : 5'($urandom_range(28));
          end
          send_command(c);
        end
        burst = $urandom_range(1, 5);
        repeat (burst) begin
          c                = rand_cmd();
          c.mode           = dcc_lpb_pkg::MODE_POLL;
          c.generator_busy = ($urandom_range(3) == 0);
          send_command(c);
        end
      end
    end
    cmd_if.valid <= 1'b0;

    // Drain, then wait for any stray packet
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("dcc_loco_packet_builder_tb: clean");
    else
      $display("dcc_loco_packet_builder_tb: errors");
    $finish;
  end

endmodule
